>>> sv/gcsr_pkg.sv
`default_nettype none

package gcsr_pkg;

  // core shape, fixed for this build
  localparam int THREADS_PER_WARP = 32;
  localparam int WARPS_PER_CORE   = 32;
  localparam int CORE_COUNT       = 16;
  localparam int FLOAT_SLOTS      = 32;

  // stream payload widths
  localparam int IN_BITS   = 56;
  localparam int OUT_BITS  = 32;
  localparam int CORE_BITS = 8;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_RETIRE = 2'd3
  } mode_t;

  // register addresses
  localparam logic [11:0] A_FFLAGS    = 12'h001;
  localparam logic [11:0] A_FRM       = 12'h002;
  localparam logic [11:0] A_FCSR      = 12'h003;
  localparam logic [11:0] A_WTID      = 12'h020;
  localparam logic [11:0] A_LTID      = 12'h021;
  localparam logic [11:0] A_GTID      = 12'h022;
  localparam logic [11:0] A_LWID      = 12'h023;
  localparam logic [11:0] A_GCID      = 12'h024;
  localparam logic [11:0] A_GWID      = 12'hF14;
  localparam logic [11:0] A_NT        = 12'hFC0;
  localparam logic [11:0] A_NW        = 12'hFC1;
  localparam logic [11:0] A_NC        = 12'hFC2;
  localparam logic [11:0] A_CYCLE     = 12'hC00;
  localparam logic [11:0] A_CYCLE_H   = 12'hC80;
  localparam logic [11:0] A_INSTRET   = 12'hC02;
  localparam logic [11:0] A_INSTRET_H = 12'hC82;

endpackage

`default_nettype wire

>>> sv/gcsr_ram.sv
`default_nettype none

module gcsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/gpu_core_csr_file_unit.sv
`default_nettype none

// CSR unit of one GPU core. Each input transaction is a CSR read, a CSR write, a
// cycle tick or an instruction-retire event; only reads return a transaction on
// the output stream, in order. One transaction is taken per clock unless the output
// stalls or the RAM is being cleared, bounded by the single read port of the general
// CSR RAM; a read passes the input stage, then the output register. Per-warp float
// status (fflags, frm, fcsr) sits in flops, id and count registers are computed from
// the access and core_number, and the 64-bit cycle and instret counters are read as
// low/high halves. After reset the general CSR RAM is swept to zero, one entry a
// cycle, so s_tready stays low until the sweep ends; core_number may be written then.
// The user must write core_number only while idle; the block does not enforce it.
module gpu_core_csr_file_unit #(
  parameter int CSR_ENTRIES = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // lsb up: mode[1:0], csr_address[13:2], write_value[45:14],
  // thread_index[50:46], warp_index[55:51]
  input  wire logic [gcsr_pkg::IN_BITS-1:0]   s_tdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // lsb up: read_data[31:0]
  output logic      [gcsr_pkg::OUT_BITS-1:0]  m_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // core_number
  input  wire logic [gcsr_pkg::CORE_BITS-1:0] cfg_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready
);

  import gcsr_pkg::*;

  localparam int AW = $clog2(CSR_ENTRIES);

  // input field unpack
  mode_t       in_mode;
  logic [11:0] in_addr;
  logic [31:0] in_value;
  logic [4:0]  in_tid;
  logic [4:0]  in_wid;

  assign in_mode  = mode_t'(s_tdata[1:0]);
  assign in_addr  = s_tdata[13:2];
  assign in_value = s_tdata[45:14];
  assign in_tid   = s_tdata[50:46];
  assign in_wid   = s_tdata[55:51];

  logic s_fire;
  logic advance;
  logic in_is_float;
  logic in_warp_ok;
  logic in_in_range;

  // state
  logic [CORE_BITS-1:0] core_number;
  logic [7:0]           float_status [FLOAT_SLOTS];
  logic [63:0]          cycle_count;
  logic [63:0]          retired_count;
  logic                 clearing;
  logic [AW-1:0]        clear_addr;

  // input stage, holds a read until it reaches the output register
  logic        s1_valid;
  logic [11:0] s1_addr;
  logic [4:0]  s1_tid;
  logic [4:0]  s1_wid;
  logic        s1_warp_ok;
  logic        s1_in_range;
  logic [31:0] ram_rdata;
  logic [31:0] rd_value;

  // ram write port, shared by the clearing sweep and csr writes
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;

  assign cfg_ready = 1'b1;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!s1_valid || advance);
  assign s_fire   = s_tvalid && s_tready;

  assign in_is_float = (in_addr == A_FFLAGS) || (in_addr == A_FRM) || (in_addr == A_FCSR);
  assign in_warp_ok  = (32'(in_wid) < 32'(WARPS_PER_CORE));
  assign in_in_range = ({1'b0, in_addr} < 13'(CSR_ENTRIES));

  // every state update happens as the transaction is taken, so a read taken
  // next cycle already sees it
  assign ram_we    = clearing || (s_fire && (in_mode == MODE_WRITE) && !in_is_float
                                 && in_in_range);
  assign ram_waddr = clearing ? clear_addr : in_addr[AW-1:0];
  assign ram_wdata = clearing ? 32'd0 : in_value;

  gcsr_ram #(
    .WIDTH (32),
    .DEPTH (CSR_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s_fire),
    .raddr (in_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // clearing sweep of the general csr ram
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == AW'(CSR_ENTRIES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      core_number <= '0;
    end else if (cfg_valid) begin
      core_number <= cfg_data;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count   <= '0;
      retired_count <= '0;
    end else if (s_fire) begin
      if (in_mode == MODE_TICK) begin
        cycle_count <= cycle_count + 64'd1;
      end
      if (in_mode == MODE_RETIRE) begin
        retired_count <= retired_count + 64'd1;
      end
    end
  end

  // per-warp float status: flags in bits 4..0, rounding mode in bits 7..5
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FLOAT_SLOTS; i++) begin
        float_status[i] <= '0;
      end
    end else if (s_fire && (in_mode == MODE_WRITE) && in_is_float && in_warp_ok) begin
      case (in_addr)
        A_FFLAGS: float_status[in_wid] <= {float_status[in_wid][7:5], in_value[4:0]};
        A_FRM:    float_status[in_wid] <= {in_value[2:0], float_status[in_wid][4:0]};
        default:  float_status[in_wid] <= in_value[7:0];
      endcase
    end
  end

  // input stage: only reads go on, other modes finish on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= (in_mode == MODE_READ);
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_addr     <= in_addr;
      s1_tid      <= in_tid;
      s1_wid      <= in_wid;
      s1_warp_ok  <= in_warp_ok;
      s1_in_range <= in_in_range;
    end
  end

  // read value select
  logic [7:0]  fs;
  logic [31:0] ltid;
  logic [31:0] core_thread_base;
  logic [31:0] core_warp_base;

  assign fs               = s1_warp_ok ? float_status[s1_wid] : 8'd0;
  assign ltid             = 32'(s1_tid) + 32'(s1_wid) * 32'(THREADS_PER_WARP);
  assign core_thread_base = 32'(THREADS_PER_WARP * WARPS_PER_CORE) * 32'(core_number);
  assign core_warp_base   = 32'(WARPS_PER_CORE) * 32'(core_number);

  always_comb begin
    case (s1_addr)
      A_FFLAGS:    rd_value = {27'd0, fs[4:0]};
      A_FRM:       rd_value = {29'd0, fs[7:5]};
      A_FCSR:      rd_value = {24'd0, fs};
      A_WTID:      rd_value = 32'(s1_tid);
      A_LTID:      rd_value = ltid;
      A_GTID:      rd_value = ltid + core_thread_base;
      A_LWID:      rd_value = 32'(s1_wid);
      A_GWID:      rd_value = 32'(s1_wid) + core_warp_base;
      A_GCID:      rd_value = 32'(core_number);
      A_NT:        rd_value = 32'(THREADS_PER_WARP);
      A_NW:        rd_value = 32'(WARPS_PER_CORE);
      A_NC:        rd_value = 32'(CORE_COUNT);
      A_CYCLE:     rd_value = cycle_count[31:0];
      A_CYCLE_H:   rd_value = cycle_count[63:32];
      A_INSTRET:   rd_value = retired_count[31:0];
      A_INSTRET_H: rd_value = retired_count[63:32];
      default:     rd_value = s1_in_range ? ram_rdata : 32'd0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= rd_value;
    end
  end

endmodule

`default_nettype wire

>>> sv/gcsr_checker.sv
`default_nettype none

module gcsr_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic [gcsr_pkg::IN_BITS-1:0]   s_tdata,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [gcsr_pkg::OUT_BITS-1:0]  m_tdata,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);

  import gcsr_pkg::*;

  logic read_fire;
  assign read_fire = s_tvalid && s_tready && (s_tdata[1:0] == MODE_READ);

  // a stalled output transaction holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // the ram sweep keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open during ram clearing");

  // an accepted read has a result waiting once it has passed the input stage and output register
  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    read_fire |-> ##2 m_tvalid)
    else $error("accepted read produced no result");

  // config port never pushes back
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind gpu_core_csr_file_unit gcsr_checker u_gcsr_checker (.*);

`default_nettype wire

>>> tb/gpu_core_csr_file_unit_tb.sv
`timescale 1ns / 100ps

module gpu_core_csr_file_unit_tb;
  import gcsr_pkg::*;

  localparam int STORE_DEPTH   = 4096;
  localparam int SETTLE_CYCLES = 8;      // room for a read to pass the input stage and output register
  localparam int LONG_HOLD     = 300;    // output held off this long once
  localparam int QUIET_LIMIT   = 20000;  // longer than the clearing sweep after reset
  localparam int PHASE_ITEMS   = 285;
  localparam int MAX_SHOWN     = 50;

  // every address that does not simply land in the general store
  localparam logic [11:0] SPECIAL_ADDRS [16] = '{
    A_FFLAGS, A_FRM, A_FCSR, A_WTID, A_LTID, A_GTID, A_LWID, A_GCID,
    A_GWID, A_NT, A_NW, A_NC, A_CYCLE, A_CYCLE_H, A_INSTRET, A_INSTRET_H
  };

  typedef struct {
    mode_t       mode;
    logic [11:0] addr;
    logic [31:0] value;
    logic [4:0]  tid;
    logic [4:0]  wid;
  } csr_access_t;

  typedef enum {CHK_OK, CHK_MISMATCH, CHK_UNEXPECTED} read_check_t;

  // shadow of the csr state; predicts read data in acceptance order
  class csr_tracker;
    logic [7:0]  core_num;
    logic [31:0] gen_regs [STORE_DEPTH];
    logic [7:0]  fstatus [FLOAT_SLOTS];
    logic [63:0] cycles;
    logic [63:0] retired;
    logic [31:0] pending_reads [$];
    int unsigned reads_done;

    function new();
      core_num = '0;
      foreach (gen_regs[i]) gen_regs[i] = '0;
      foreach (fstatus[i]) fstatus[i] = '0;
      cycles = '0;
      retired = '0;
      reads_done = 0;
    endfunction

    function bit warp_in_core(logic [4:0] w);
      return int'(w) < WARPS_PER_CORE && int'(w) < FLOAT_SLOTS;
    endfunction

    function logic [31:0] read_value(logic [11:0] a, logic [4:0] t, logic [4:0] w);
      logic [31:0] nt, nw, tid, wid, core;
      nt = 32'(THREADS_PER_WARP);
      nw = 32'(WARPS_PER_CORE);
      tid = 32'(t);
      wid = 32'(w);
      core = 32'(core_num);
      case (a)
        A_FFLAGS:    return warp_in_core(w) ? {27'd0, fstatus[w][4:0]} : 32'd0;
        A_FRM:       return warp_in_core(w) ? {29'd0, fstatus[w][7:5]} : 32'd0;
        A_FCSR:      return warp_in_core(w) ? {24'd0, fstatus[w]} : 32'd0;
        A_WTID:      return tid;
        A_LTID:      return tid + wid * nt;
        A_GTID:      return tid + wid * nt + nt * nw * core;
        A_LWID:      return wid;
        A_GWID:      return wid + nw * core;
        A_GCID:      return core;
        A_NT:        return nt;
        A_NW:        return nw;
        A_NC:        return 32'(CORE_COUNT);
        A_CYCLE:     return cycles[31:0];
        A_CYCLE_H:   return cycles[63:32];
        A_INSTRET:   return retired[31:0];
        A_INSTRET_H: return retired[63:32];
        default:     return (int'(a) < STORE_DEPTH) ? gen_regs[a] : 32'd0;
      endcase
    endfunction

    function void apply_write(logic [11:0] a, logic [31:0] v, logic [4:0] w);
      if (a == A_FFLAGS || a == A_FRM || a == A_FCSR) begin
        if (!warp_in_core(w)) return;
        case (a)
          A_FFLAGS: fstatus[w][4:0] = v[4:0];
          A_FRM:    fstatus[w][7:5] = v[2:0];
          default:  fstatus[w] = v[7:0];
        endcase
      end else if (int'(a) < STORE_DEPTH) begin
        gen_regs[a] = v;
      end
    endfunction

    // called once per accepted input transaction
    function void note_access(csr_access_t acc);
      case (acc.mode)
        MODE_READ:  pending_reads.push_back(read_value(acc.addr, acc.tid, acc.wid));
        MODE_WRITE: apply_write(acc.addr, acc.value, acc.wid);
        MODE_TICK:  cycles = cycles + 64'd1;
        default:    retired = retired + 64'd1;
      endcase
    endfunction

    // called once per accepted output transaction
    function read_check_t check_read_data(input logic [31:0] got, output logic [31:0] want);
      want = '0;
      if (pending_reads.size() == 0) return CHK_UNEXPECTED;
      want = pending_reads.pop_front();
      reads_done++;
      return (got === want) ? CHK_OK : CHK_MISMATCH;
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic [IN_BITS-1:0]   s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [OUT_BITS-1:0]  m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [CORE_BITS-1:0] cfg_data = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;

  csr_tracker tracker = new();
  int unsigned error_count = 0;
  int unsigned access_count = 0;
  int unsigned core_writes = 0;
  bit steady_flow = 1'b0;  // both sides stop idling while set

  gpu_core_csr_file_unit #(.CSR_ENTRIES(STORE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic csr_access_t make_access(mode_t m, logic [11:0] a, logic [31:0] v,
                                              logic [4:0] t, logic [4:0] w);
    csr_access_t acc;
    acc.mode = m;
    acc.addr = a;
    acc.value = v;
    acc.tid = t;
    acc.wid = w;
    return acc;
  endfunction

  // mostly reads and writes on addresses that matter, with a few ticks and retires
  function automatic csr_access_t random_access();
    csr_access_t acc;
    int unsigned r;
    r = $urandom_range(99);
    acc.mode = (r < 45) ? MODE_READ : (r < 75) ? MODE_WRITE : (r < 90) ? MODE_TICK : MODE_RETIRE;
    r = $urandom_range(99);
    if (r < 40) acc.addr = SPECIAL_ADDRS[$urandom_range(15)];
    else if (r < 48) acc.addr = $urandom_range(1) ? 12'hFFF : 12'h000;
    else if (r < 80) acc.addr = 12'h100 + 12'($urandom_range(15));  // reuse window
    else acc.addr = 12'($urandom);
    r = $urandom_range(9);
    acc.value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    acc.tid = 5'($urandom);
    // a few warps get hit often so float status writes are read back
    acc.wid = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom);
    return acc;
  endfunction

  // offer one input transaction, idling at random first
  task automatic send_access(input csr_access_t acc);
    while (!steady_flow && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {acc.wid, acc.tid, acc.value, acc.addr, acc.mode};
    do @(posedge clk); while (!s_tready);
    tracker.note_access(acc);
    access_count++;
  endtask

  // all reads answered, then room for a trailing write still in flight
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_core_number(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.core_num = v;
    core_writes++;
  endtask

  // output side: random back pressure, one long hold once reads are flowing
  initial begin : sink_driver
    bit held_once;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && tracker.reads_done >= 300) begin
        held_once = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      m_tready <= steady_flow || ($urandom_range(99) >= 13);
    end
  end

  // every output transaction against the oldest predicted read
  always @(posedge clk) begin : read_data_monitor
    logic [31:0] want;
    if (!rst && m_tvalid && m_tready) begin
      case (tracker.check_read_data(m_tdata, want))
        CHK_UNEXPECTED:
          report_mismatch($sformatf("read_data %08h with no read outstanding", m_tdata));
        CHK_MISMATCH:
          report_mismatch($sformatf("read_data %08h, expected %08h", m_tdata, want));
        default: ;
      endcase
    end
  end

  // ends the run if no transaction moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("** gpu_core_csr_file_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] core_settings [6];
    core_settings = '{8'hFF, 8'h00, 8'($urandom), 8'h01, 8'($urandom), 8'hFF};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset core_number; waits out the clearing sweep
    send_access(make_access(MODE_WRITE, A_FFLAGS, 32'hFFFF_FFFF, 5'd0, 5'd0));
    send_access(make_access(MODE_WRITE, A_FRM, 32'hFFFF_FFFF, 5'd0, 5'd31));  // masked to 3 bits
    send_access(make_access(MODE_READ, A_FCSR, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_FCSR, 32'h0, 5'd0, 5'd31));
    send_access(make_access(MODE_WRITE, A_FCSR, 32'h0000_01A5, 5'd0, 5'd5));
    send_access(make_access(MODE_READ, A_FFLAGS, 32'h0, 5'd0, 5'd5));
    send_access(make_access(MODE_READ, A_FRM, 32'h0, 5'd0, 5'd5));
    // id registers at the top thread and warp
    send_access(make_access(MODE_READ, A_WTID, 32'h0, 5'd31, 5'd31));
    send_access(make_access(MODE_READ, A_LTID, 32'h0, 5'd31, 5'd31));
    send_access(make_access(MODE_READ, A_GTID, 32'h0, 5'd31, 5'd31));
    send_access(make_access(MODE_READ, A_LWID, 32'h0, 5'd0, 5'd31));
    send_access(make_access(MODE_READ, A_GWID, 32'h0, 5'd0, 5'd31));
    send_access(make_access(MODE_READ, A_GCID, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_NT, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_NW, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_NC, 32'h0, 5'd0, 5'd0));
    // counters, ticks and retires return nothing
    send_access(make_access(MODE_TICK, 12'h000, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_TICK, 12'h000, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_RETIRE, 12'h000, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_CYCLE, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_CYCLE_H, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_INSTRET, 32'h0, 5'd0, 5'd0));
    // top of the general store, then a write that must not shadow an id register
    send_access(make_access(MODE_WRITE, 12'hFFF, 32'hFFFF_FFFF, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, 12'hFFF, 32'h0, 5'd0, 5'd0));
    send_access(make_access(MODE_WRITE, A_GTID, 32'hDEAD_BEEF, 5'd0, 5'd0));
    send_access(make_access(MODE_READ, A_GTID, 32'h0, 5'd7, 5'd3));

    // random phases, each under its own core_number
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_core_number(core_settings[p]);
      steady_flow = (p == 2);
      repeat (PHASE_ITEMS) send_access(random_access());
    end
    steady_flow = 1'b0;

    wait_idle();
    if (tracker.pending_reads.size() != 0)
      report_mismatch($sformatf("%0d reads never answered", tracker.pending_reads.size()));

    $display("covered %0d input transactions, %0d reads checked, %0d core_number writes",
             access_count, tracker.reads_done, core_writes);
    $display("final counters: cycle %0d, instret %0d", tracker.cycles, tracker.retired);
    if (error_count == 0)
      $display("** gpu_core_csr_file_unit: PASSED **");
    else
      $display("** gpu_core_csr_file_unit: FAILED **");
    $finish;
  end

endmodule
